/* sv/spv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spv_pkg: stereo sample playback voice package
// Widths, codes, config record and helper functions shared by the voice.
// ----------------------------------------------------------------------------
package spv_pkg;

    localparam int BUFFER_FRAMES = 65536;
    localparam int ADDR_W        = $clog2(BUFFER_FRAMES);
    localparam int FRAC_BITS     = 16;
    localparam int FRAME_W       = ADDR_W + 1;           // integer part, holds the length
    localparam int POS_W         = FRAME_W + FRAC_BITS;
    localparam int SAMPLE_W      = 16;
    localparam int WORD_W        = 2 * SAMPLE_W;

    localparam int REQ_W         = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 17;
    localparam int FREQ_W        = 17;
    localparam int VOL_W         = 8;
    localparam int PAN_W         = 9;
    localparam int LEN_W         = 17;

    localparam int UNITY         = 128;
    localparam int GAIN_W        = 8;
    localparam int VG_W          = 15;                   // vol*gain <= 16384
    localparam int GAIN_SHIFT    = 14;                   // divide by 16384

    // step = floor(freq * 2^FRAC_BITS / 22050) as freq * STEP_MUL >> STEP_K,
    // exact for every 17-bit frequency
    localparam longint unsigned BASE_RATE = 64'd22050;
    localparam int STEP_K        = 32;
    localparam int STEP_MUL_W    = 34;
    localparam int STEP_HALF_W   = STEP_MUL_W / 2;
    localparam logic [STEP_MUL_W-1:0] STEP_MUL = STEP_MUL_W'(
        ((64'd1 << (FRAC_BITS + STEP_K)) + BASE_RATE - 64'd1) / BASE_RATE);
    localparam int PP_W          = FREQ_W + STEP_HALF_W;
    localparam int STEP_SUM_W    = PP_W + STEP_HALF_W;
    localparam int STEP_W        = STEP_SUM_W - STEP_K;

    localparam int MOD_STEPS     = FRAME_W;
    localparam int MOD_CNT_W     = $clog2(MOD_STEPS + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD = 2'd0,
        REQ_TICK = 2'd1,
        REQ_PLAY = 2'd2,
        REQ_STOP = 2'd3
    } req_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQ   = 3'd0,
        CFG_VOLUME = 3'd1,
        CFG_PAN    = 3'd2,
        CFG_LOOP   = 3'd3,
        CFG_LENGTH = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIX,
        ST_MOD,
        ST_READ,
        ST_MUL
    } state_t;

    typedef struct packed {
        logic [FREQ_W-1:0]        freq;
        logic [VOL_W-1:0]         vol;
        logic signed [PAN_W-1:0]  pan;
        logic                     loop_en;
        logic [LEN_W-1:0]         len;
    } cfg_t;

    typedef struct packed {
        logic [VG_W-1:0] vg_l;
        logic [VG_W-1:0] vg_r;
        logic [PP_W-1:0] pp_lo;
        logic [PP_W-1:0] pp_hi;
    } coef_t;

    function automatic logic [GAIN_W-1:0] clamp_gain(input logic signed [PAN_W+1:0] g);
        logic [GAIN_W-1:0] r;
        if (g < 0)
            r = '0;
        else if (g > (PAN_W+2)'(UNITY))
            r = GAIN_W'(UNITY);
        else
            r = g[GAIN_W-1:0];
        return r;
    endfunction

    // p / 16384 truncated toward zero
    function automatic logic signed [SAMPLE_W-1:0] scale_q14(input logic signed [WORD_W-1:0] p);
        logic signed [WORD_W-1:0] b;
        b = p + ((p < 0) ? WORD_W'((1 << GAIN_SHIFT) - 1) : '0);
        return SAMPLE_W'(b >>> GAIN_SHIFT);
    endfunction

endpackage

/* sv/spv_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spv_req_if: request channel
// Valid/ready channel carrying one voice request per beat.
// ----------------------------------------------------------------------------
interface spv_req_if;
    import spv_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [REQ_W-1:0]           req_type;
    logic [ADDR_W-1:0]          frame_address;
    logic signed [SAMPLE_W-1:0] load_left;
    logic signed [SAMPLE_W-1:0] load_right;

    modport source (output valid, req_type, frame_address, load_left, load_right,
                    input ready);
    modport sink   (input valid, req_type, frame_address, load_left, load_right,
                    output ready);
endinterface

/* sv/spv_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spv_res_if: result channel
// Valid/ready channel carrying one output frame and voice status per beat.
// ----------------------------------------------------------------------------
interface spv_res_if;
    import spv_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       active;
    logic [FRAME_W-1:0]         current_frame;

    modport source (output valid, out_left, out_right, active, current_frame,
                    input ready);
    modport sink   (input valid, out_left, out_right, active, current_frame,
                    output ready);
endinterface

/* sv/spv_cfg_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spv_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
interface spv_cfg_if;
    import spv_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/stereo_sample_playback_voice.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_sample_playback_voice: stereo sample playback voice
// Sample store, play position and nearest-neighbor scaled output per tick.
// ----------------------------------------------------------------------------
//  channel | dir | beat carries
//  --------+-----+-----------------------------------------------------
//  req     | in  | req_type, frame_address, load_left, load_right
//  res     | out | out_left, out_right, active, current_frame
//  cfg     | in  | index, data (always ready)
//
//  Load, play, stop and silent tick: result registered at accept.
//  Playing tick: frame read at accept, multiply and advance, end check;
//  a position past the end before the read adds an end check and a read,
//  and each end check needing the remainder waits for it (17-bit dividend).
//  Reset clears control and config; the sample store is not cleared.
//  req is taken only while idle and the result register is free or draining.
// ----------------------------------------------------------------------------
module stereo_sample_playback_voice (
    input  logic    clk,
    input  logic    rst_n,
    spv_req_if.sink   req,
    spv_res_if.source res,
    spv_cfg_if.sink   cfg
);
    import spv_pkg::*;

    state_t                    state_reg, state_next;
    logic                      phase_reg, phase_next;   // 1: after advance
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic                      playing_reg, playing_next;
    cfg_t                      cfg_reg;
    coef_t                     coef;

    logic                      res_valid_reg, res_valid_next;
    logic signed [SAMPLE_W-1:0] res_left_reg, res_left_next;
    logic signed [SAMPLE_W-1:0] res_right_reg, res_right_next;
    logic                      res_play_reg, res_play_next;
    logic [FRAME_W-1:0]        res_frame_reg, res_frame_next;

    logic signed [WORD_W-1:0]  prod_l_reg, prod_l_next;
    logic signed [WORD_W-1:0]  prod_r_reg, prod_r_next;

    logic                      in_fire;
    req_t                      req_kind;
    logic                      audible;
    logic [LEN_W-1:0]          len_eff;
    logic [FRAME_W-1:0]        ipos, ipos_sub;
    logic [FRAC_BITS-1:0]      frac;
    logic                      in_range, can_loop, below2;
    logic [STEP_SUM_W-1:0]     step_sum;
    logic [STEP_W-1:0]         step;
    logic signed [SAMPLE_W-1:0] scaled_l, scaled_r;

    logic                      mem_we, mem_re;
    logic [WORD_W-1:0]         mem_rdata;
    logic signed [SAMPLE_W-1:0] rd_sl, rd_sr;

    logic                      mod_start, mod_done;
    logic [FRAME_W-1:0]        mod_rem;

    spv_sample_mem u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (req.frame_address),
        .wdata ({req.load_right, req.load_left}),
        .re    (mem_re),
        .raddr (pos_reg[FRAC_BITS +: ADDR_W]),
        .rdata (mem_rdata)
    );

    spv_mod_unit u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (ipos),
        .divisor  (len_eff),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    spv_coef u_coef (
        .clk  (clk),
        .cfg  (cfg_reg),
        .coef (coef)
    );

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.freq    <= '0;
            cfg_reg.vol     <= VOL_W'(UNITY);
            cfg_reg.pan     <= '0;
            cfg_reg.loop_en <= 1'b0;
            cfg_reg.len     <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg_idx_t'(cfg.index))
                CFG_FREQ:   cfg_reg.freq    <= cfg.data[FREQ_W-1:0];
                CFG_VOLUME: cfg_reg.vol     <= cfg.data[VOL_W-1:0];
                CFG_PAN:    cfg_reg.pan     <= cfg.data[PAN_W-1:0];
                CFG_LOOP:   cfg_reg.loop_en <= cfg.data[0];
                CFG_LENGTH: cfg_reg.len     <= cfg.data[LEN_W-1:0];
                default:    ;
            endcase
        end
    end

    // shared position and end-of-buffer terms
    always_comb
    begin
        req.ready = (state_reg == ST_IDLE) && (!res_valid_reg || res.ready);
        in_fire   = req.valid && req.ready;
        req_kind  = req_t'(req.req_type);
        audible   = playing_reg && (cfg_reg.freq != '0) && (cfg_reg.vol != '0);
        len_eff   = (cfg_reg.len > LEN_W'(BUFFER_FRAMES)) ? LEN_W'(BUFFER_FRAMES)
                                                          : cfg_reg.len;
        ipos      = pos_reg[POS_W-1:FRAC_BITS];
        frac      = pos_reg[FRAC_BITS-1:0];
        in_range  = ipos < len_eff;
        can_loop  = cfg_reg.loop_en && (len_eff != '0);
        below2    = {1'b0, ipos} < {len_eff, 1'b0};
        ipos_sub  = ipos - len_eff;
        step_sum  = {coef.pp_hi, {STEP_HALF_W{1'b0}}} + STEP_SUM_W'(coef.pp_lo);
        step      = step_sum[STEP_SUM_W-1:STEP_K];
        scaled_l  = scale_q14(prod_l_reg);
        scaled_r  = scale_q14(prod_r_reg);
        rd_sl     = mem_rdata[SAMPLE_W-1:0];
        rd_sr     = mem_rdata[WORD_W-1:SAMPLE_W];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (req_kind == REQ_TICK) && audible)
                    state_next = in_range ? ST_MUL : ST_FIX;
            end
            ST_FIX:
            begin
                if (in_range || !can_loop || below2)
                    state_next = (phase_reg || !in_range && !can_loop) ? ST_IDLE : ST_READ;
                else
                    state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (mod_done)
                    state_next = phase_reg ? ST_IDLE : ST_READ;
            end
            ST_READ: state_next = ST_MUL;
            ST_MUL:  state_next = ST_FIX;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        pos_next       = pos_reg;
        playing_next   = playing_reg;
        phase_next     = phase_reg;
        res_valid_next = res_valid_reg && !res.ready;
        res_left_next  = res_left_reg;
        res_right_next = res_right_reg;
        res_play_next  = res_play_reg;
        res_frame_next = res_frame_reg;
        prod_l_next    = prod_l_reg;
        prod_r_next    = prod_r_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mod_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    phase_next     = 1'b0;
                    res_left_next  = '0;
                    res_right_next = '0;
                    res_play_next  = playing_reg;
                    res_frame_next = ipos;
                    res_valid_next = 1'b1;
                    case (req_kind)
                        REQ_LOAD: mem_we = 1'b1;
                        REQ_PLAY:
                        begin
                            pos_next       = {1'b0, req.frame_address, {FRAC_BITS{1'b0}}};
                            playing_next   = 1'b1;
                            res_play_next  = 1'b1;
                            res_frame_next = {1'b0, req.frame_address};
                        end
                        REQ_STOP:
                        begin
                            playing_next  = 1'b0;
                            res_play_next = 1'b0;
                        end
                        REQ_TICK:
                        begin
                            if (audible)
                            begin
                                res_valid_next = 1'b0;
                                mem_re         = in_range;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FIX:
            begin
                if (in_range)
                begin
                    if (phase_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_left_next  = scaled_l;
                        res_right_next = scaled_r;
                        res_play_next  = playing_reg;
                        res_frame_next = ipos;
                    end
                end
                else if (!can_loop)
                begin
                    // stop at the end; frame is kept only if it was read
                    playing_next   = 1'b0;
                    pos_next       = '0;
                    res_valid_next = 1'b1;
                    res_left_next  = phase_reg ? scaled_l : '0;
                    res_right_next = phase_reg ? scaled_r : '0;
                    res_play_next  = 1'b0;
                    res_frame_next = '0;
                end
                else if (below2)
                begin
                    pos_next = {ipos_sub, frac};
                    if (phase_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_left_next  = scaled_l;
                        res_right_next = scaled_r;
                        res_play_next  = playing_reg;
                        res_frame_next = ipos_sub;
                    end
                end
                else
                begin
                    mod_start = 1'b1;
                end
            end
            ST_MOD:
            begin
                if (mod_done)
                begin
                    pos_next = {mod_rem, frac};
                    if (phase_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_left_next  = scaled_l;
                        res_right_next = scaled_r;
                        res_play_next  = playing_reg;
                        res_frame_next = mod_rem;
                    end
                end
            end
            ST_READ:
            begin
                mem_re = 1'b1;
            end
            ST_MUL:
            begin
                prod_l_next = rd_sl * $signed({1'b0, coef.vg_l});
                prod_r_next = rd_sr * $signed({1'b0, coef.vg_r});
                pos_next    = pos_reg + POS_W'(step);
                phase_next  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= 1'b0;
            pos_reg       <= '0;
            playing_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            playing_reg   <= playing_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_left_reg  <= res_left_next;
        res_right_reg <= res_right_next;
        res_play_reg  <= res_play_next;
        res_frame_reg <= res_frame_next;
        prod_l_reg    <= prod_l_next;
        prod_r_reg    <= prod_r_next;
    end

    assign res.valid         = res_valid_reg;
    assign res.out_left      = res_left_reg;
    assign res.out_right     = res_right_reg;
    assign res.active        = res_play_reg;
    assign res.current_frame = res_frame_reg;

    // remainder only completes while the FSM waits for it
    a_mod_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == ST_MOD))
        else $error("remainder done outside wait state");

    // multiply and advance always hands over to the post-advance end check
    a_mul_to_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |=> (state_reg == ST_FIX) && phase_reg)
        else $error("advance not followed by end check");

    // one advance past a wrapped position stays a few frames past the store
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ipos < FRAME_W'(BUFFER_FRAMES + 8))
        else $error("play position out of bound");
endmodule

/* sv/spv_sample_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spv_sample_mem: stereo frame store
// One write port, one registered read port. Left in low half, right in high.
// ----------------------------------------------------------------------------
module spv_sample_mem (
    input  logic                       clk,
    input  logic                       we,
    input  logic [spv_pkg::ADDR_W-1:0] waddr,
    input  logic [spv_pkg::WORD_W-1:0] wdata,
    input  logic                       re,
    input  logic [spv_pkg::ADDR_W-1:0] raddr,
    output logic [spv_pkg::WORD_W-1:0] rdata
);
    import spv_pkg::*;

    logic [WORD_W-1:0] mem [BUFFER_FRAMES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* sv/spv_mod_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spv_mod_unit: iterative remainder
// Restoring remainder, one dividend bit per cycle; done pulses when rem valid.
// ----------------------------------------------------------------------------
module spv_mod_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [spv_pkg::FRAME_W-1:0] dividend,
    input  logic [spv_pkg::LEN_W-1:0]   divisor,
    output logic                        done,
    output logic [spv_pkg::FRAME_W-1:0] rem
);
    import spv_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [FRAME_W:0]     rem_reg, rem_next;
    logic [FRAME_W-1:0]   num_reg, num_next;
    logic [LEN_W-1:0]     div_reg, div_next;
    logic [FRAME_W:0]     trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        div_next  = div_reg;
        trial     = {rem_reg[FRAME_W-1:0], num_reg[FRAME_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = MOD_CNT_W'(MOD_STEPS);
            rem_next  = '0;
            num_next  = dividend;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
                rem_next = trial - {1'b0, div_reg};
            else
                rem_next = trial;
            num_next = {num_reg[FRAME_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == MOD_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg[FRAME_W-1:0];
endmodule

/* sv/spv_coef.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spv_coef: channel gains and step partial products
// Registers vol*gain per channel and freq times each half of STEP_MUL.
// ----------------------------------------------------------------------------
module spv_coef (
    input  logic           clk,
    input  spv_pkg::cfg_t  cfg,
    output spv_pkg::coef_t coef
);
    import spv_pkg::*;

    logic [VOL_W-1:0]         vol_sat;
    logic signed [PAN_W+1:0]  pan_ext;
    logic [GAIN_W-1:0]        gain_l, gain_r;
    coef_t                    coef_next;

    always_comb
    begin
        vol_sat = (cfg.vol > VOL_W'(UNITY)) ? VOL_W'(UNITY) : cfg.vol;
        pan_ext = (PAN_W+2)'(cfg.pan);
        gain_l  = clamp_gain((PAN_W+2)'(UNITY) - pan_ext);
        gain_r  = clamp_gain((PAN_W+2)'(UNITY) + pan_ext);
        coef_next.vg_l  = VG_W'(vol_sat) * VG_W'(gain_l);
        coef_next.vg_r  = VG_W'(vol_sat) * VG_W'(gain_r);
        coef_next.pp_lo = PP_W'(cfg.freq) * PP_W'(STEP_MUL[STEP_HALF_W-1:0]);
        coef_next.pp_hi = PP_W'(cfg.freq) * PP_W'(STEP_MUL[STEP_MUL_W-1:STEP_HALF_W]);
    end

    always_ff @(posedge clk)
    begin
        coef <= coef_next;
    end
endmodule

/* tb/sv/tb_stereo_sample_playback_voice.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stereo_sample_playback_voice: stereo playback voice testbench
// Drives load, play, stop and tick beats under several idle and stall mixes,
// predicts each output frame and status, and compares every result beat
// against the oldest prediction. Settings are rewritten only while idle.
// ----------------------------------------------------------------------------
module tb_stereo_sample_playback_voice;
    import spv_pkg::*;

    localparam int SETTLE         = 60;     // covers the slowest tick with two remainders
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 110;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       playing;
        logic [FRAME_W-1:0]         frame;
    } voice_frame_t;

    class playback_scoreboard;
        localparam longint Q14_DIV    = longint'(1) << GAIN_SHIFT;

        logic [WORD_W-1:0] frames [BUFFER_FRAMES];
        bit                loaded [BUFFER_FRAMES];
        longint unsigned   position;
        bit                playing;
        cfg_t              settings;
        voice_frame_t      expected_q [$];
        int                errors;

        function new();
            position         = 0;
            playing          = 1'b0;
            errors           = 0;
            settings.freq    = '0;
            settings.vol     = VOL_W'(UNITY);
            settings.pan     = '0;
            settings.loop_en = 1'b0;
            settings.len     = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_FREQ:   settings.freq    = value[FREQ_W-1:0];
                CFG_VOLUME: settings.vol     = value[VOL_W-1:0];
                CFG_PAN:    settings.pan     = value[PAN_W-1:0];
                CFG_LOOP:   settings.loop_en = value[0];
                CFG_LENGTH: settings.len     = value[LEN_W-1:0];
                default:    ;
            endcase
        endfunction

        function longint unsigned span_frames();
            return (settings.len > LEN_W'(BUFFER_FRAMES)) ? BUFFER_FRAMES : settings.len;
        endfunction

        function bit audible();
            return playing && settings.freq != 0 && settings.vol != 0;
        endfunction

        // frame a tick would read next, without touching state
        function bit next_read(output int unsigned idx);
            longint unsigned span;
            longint unsigned pos;
            span = span_frames();
            pos  = position;
            idx  = 0;
            if (!audible())
                return 1'b0;
            if ((pos >> FRAC_BITS) >= span) begin
                if (!settings.loop_en || span == 0)
                    return 1'b0;
                pos = pos % (span << FRAC_BITS);
            end
            idx = int'(pos >> FRAC_BITS);
            return 1'b1;
        endfunction

        // wrap or stop at the buffer end; 0 when playback stopped
        function bit end_of_buffer();
            longint unsigned span;
            span = span_frames();
            if ((position >> FRAC_BITS) < span)
                return 1'b1;
            if (settings.loop_en && span != 0) begin
                position = position % (span << FRAC_BITS);
                return 1'b1;
            end
            playing  = 1'b0;
            position = 0;
            return 1'b0;
        endfunction

        function longint gain_clamp(longint g);
            return (g < 0) ? 0 : ((g > UNITY) ? UNITY : g);
        endfunction

        function void note_req(req_t kind, logic [ADDR_W-1:0] addr,
                               logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
            voice_frame_t      e;
            logic [WORD_W-1:0] w;
            longint            v;
            longint            pn;
            e = '0;
            case (kind)
                REQ_LOAD: begin
                    frames[addr] = {r, l};
                    loaded[addr] = 1'b1;
                end
                REQ_PLAY: begin
                    position = 64'(addr) << FRAC_BITS;
                    playing  = 1'b1;
                end
                REQ_STOP: playing = 1'b0;
                REQ_TICK: begin
                    if (audible()) begin
                        if (end_of_buffer()) begin
                            w  = frames[position >> FRAC_BITS];
                            v  = (settings.vol > VOL_W'(UNITY)) ? UNITY : longint'(settings.vol);
                            pn = longint'($signed(settings.pan));
                            e.left  = SAMPLE_W'(longint'($signed(w[SAMPLE_W-1:0])) * v
                                                * gain_clamp(UNITY - pn) / Q14_DIV);
                            e.right = SAMPLE_W'(longint'($signed(w[WORD_W-1:SAMPLE_W])) * v
                                                * gain_clamp(UNITY + pn) / Q14_DIV);
                            position += (64'(settings.freq) << FRAC_BITS) / BASE_RATE;
                            void'(end_of_buffer());
                        end
                    end
                end
                default: ;
            endcase
            e.playing = playing;
            e.frame   = FRAME_W'(position >> FRAC_BITS);
            expected_q.push_back(e);
        endfunction

        task check_res(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                       logic play, logic [FRAME_W-1:0] frame);
            voice_frame_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("result beat with nothing expected (left %0d right %0d)", l, r));
                return;
            end
            e = expected_q.pop_front();
            if (l !== e.left)
                report($sformatf("out_left %0d, expected %0d", l, e.left));
            if (r !== e.right)
                report($sformatf("out_right %0d, expected %0d", r, e.right));
            if (play !== e.playing)
                report($sformatf("active %b, expected %b", play, e.playing));
            if (frame !== e.frame)
                report($sformatf("current_frame %0d, expected %0d", frame, e.frame));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   hold_reqs;

    playback_scoreboard sb = new();

    spv_req_if req_ch ();
    spv_res_if res_ch ();
    spv_cfg_if cfg_ch ();

    stereo_sample_playback_voice dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // leaves valid high after the beat so back-to-back beats need one assignment
    task automatic send(req_t kind, logic [ADDR_W-1:0] addr,
                        logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= kind;
        req_ch.frame_address <= addr;
        req_ch.load_left     <= l;
        req_ch.load_right    <= r;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_req(kind, addr, l, r);
    endtask

    // a tick never reads a frame that was not loaded: load it first
    task automatic tick();
        int unsigned idx;
        if (sb.next_read(idx) && !sb.loaded[idx])
            send(REQ_LOAD, ADDR_W'(idx), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        send(REQ_TICK, ADDR_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.set_reg(idx, value);
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // random bits above the register width
    function automatic logic [CFG_DATA_W-1:0] with_noise(int value, int width);
        logic [CFG_DATA_W-1:0] keep;
        keep = CFG_DATA_W'((64'd1 << width) - 1);
        return (CFG_DATA_W'($urandom) & ~keep) | (CFG_DATA_W'(value) & keep);
    endfunction

    task automatic apply_settings(int f, int v, int p, int lp, int n);
        settle();
        write_reg(CFG_FREQ,   with_noise(f, FREQ_W));
        write_reg(CFG_VOLUME, with_noise(v, VOL_W));
        write_reg(CFG_PAN,    with_noise(p, PAN_W));
        write_reg(CFG_LOOP,   with_noise(lp, 1));
        write_reg(CFG_LENGTH, with_noise(n, LEN_W));
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [ADDR_W-1:0] near_addr(longint unsigned span);
        if (span >= BUFFER_FRAMES)
            return ADDR_W'(BUFFER_FRAMES - $urandom_range(1, 64));
        return ADDR_W'($urandom_range(0, int'(span) - 1));
    endfunction

    // result side: checks every beat, stalls at random, long hold-off on request
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                sb.check_res(res_ch.out_left, res_ch.out_right,
                             res_ch.active, res_ch.current_frame);
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] timeout: no beat on any channel for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int f;
        int v;
        int p;
        int lp;
        int n;
        int pick;
        longint unsigned span;
        logic [ADDR_W-1:0] a;

        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.req_type      <= REQ_LOAD;
        req_ch.frame_address <= '0;
        req_ch.load_left     <= '0;
        req_ch.load_right    <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_FREQ;
        cfg_ch.data          <= '0;
        recv_stall_pct       <= 0;
        hold_reqs            <= 0;
        send_idle_pct        = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: silent tick out of reset, sample extremes, both address ends
        tick();
        send(REQ_LOAD, 16'd0, 16'h7FFF, 16'h8000);
        send(REQ_LOAD, 16'd1, 16'h8000, 16'h7FFF);
        send(REQ_LOAD, 16'd2, 16'hFFFF, 16'h0001);
        send(REQ_LOAD, 16'hFFFF, 16'h5555, 16'hAAAA);

        // one frame per tick, looping over four frames
        apply_settings(22050, UNITY, 0, 1, 4);
        send(REQ_PLAY, 16'd0, '0, '0);
        repeat (5) tick();
        send(REQ_STOP, 16'd0, '0, '0);
        tick();
        // start past the end: folded back into the buffer
        send(REQ_PLAY, 16'hFFFF, '0, '0);
        tick();

        // no loop: past-end start stops at once, end reached stops on the tick
        apply_settings(22050, UNITY, 0, 0, 4);
        send(REQ_PLAY, 16'd10, '0, '0);
        tick();
        send(REQ_PLAY, 16'd2, '0, '0);
        tick();
        tick();

        // volume saturation and full-left pan beyond range
        apply_settings(44100, 255, -256, 1, 4);
        send(REQ_PLAY, 16'd0, '0, '0);
        tick();
        tick();

        // silent ticks: zero volume, then zero rate
        apply_settings(1, 0, 255, 1, 4);
        send(REQ_PLAY, 16'd1, '0, '0);
        tick();
        apply_settings(0, UNITY, UNITY, 1, 4);
        send(REQ_PLAY, 16'd1, '0, '0);
        tick();

        // oversized length and top rate wrap across the last frame
        apply_settings(2**FREQ_W - 1, UNITY, -UNITY, 1, 2**LEN_W - 1);
        send(REQ_PLAY, 16'hFFFF, '0, '0);
        tick();
        tick();

        // zero length with loop set still stops
        apply_settings(96000, 1, 127, 1, 0);
        send(REQ_PLAY, 16'd3, '0, '0);
        tick();

        // writes to unmapped indexes change nothing
        settle();
        for (int k = CFG_SPARE_FIRST; k < 2**CFG_IDX_W; k++)
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        cfg_ch.valid <= 1'b0;

        for (int mode = 0; mode < 4; mode++)
        begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 61; end
                default: begin send_idle_pct = 7; recv_stall_pct <= 7; end
            endcase
            for (int round = 0; round < 4; round++)
            begin
                case ($urandom_range(9))
                    0: f = 0;
                    1: f = 2**FREQ_W - 1;
                    2: f = 96000;
                    3: f = 22050 * int'($urandom_range(1, 4));
                    default: f = int'($urandom_range(1, 96000));
                endcase
                case ($urandom_range(9))
                    0: v = 0;
                    1: v = int'($urandom_range(UNITY + 1, 2**VOL_W - 1));
                    2: v = UNITY;
                    default: v = int'($urandom_range(1, UNITY));
                endcase
                case ($urandom_range(9))
                    0: p = -int'($urandom_range(UNITY + 1, 2**(PAN_W - 1)));
                    1: p = int'($urandom_range(UNITY + 1, 2**(PAN_W - 1) - 1));
                    default: p = int'($urandom_range(0, 2 * UNITY)) - UNITY;
                endcase
                lp = int'($urandom_range(1));
                case ($urandom_range(19))
                    0: n = 0;
                    1: n = BUFFER_FRAMES;
                    2: n = int'($urandom_range(BUFFER_FRAMES + 1, 2**LEN_W - 1));
                    3: n = int'($urandom_range(1000, BUFFER_FRAMES - 1));
                    default: n = int'($urandom_range(1, 48));
                endcase
                apply_settings(f, v, p, lp, n);

                // long result stall while beats keep coming: input must back up
                if (mode == 0 && round == 1)
                    hold_reqs <= hold_reqs + 1;

                span = sb.span_frames();
                repeat (PHASE_ITEMS)
                begin
                    pick = int'($urandom_range(99));
                    if (pick < 15) begin
                        a = (span == 0 || $urandom_range(9) == 0) ? ADDR_W'($urandom)
                                                                 : near_addr(span);
                        send(REQ_LOAD, a, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
                    end
                    else if (pick < 30) begin
                        a = (span == 0 || $urandom_range(4) == 0) ? ADDR_W'($urandom)
                                                                 : near_addr(span);
                        send(REQ_PLAY, a, SAMPLE_W'($urandom), SAMPLE_W'($urandom));
                    end
                    else if (pick < 36)
                        send(REQ_STOP, ADDR_W'($urandom), SAMPLE_W'($urandom),
                             SAMPLE_W'($urandom));
                    else
                        tick();
                end
            end
        end

        settle();
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* sim.f */
sv/spv_pkg.sv
sv/spv_req_if.sv
sv/spv_res_if.sv
sv/spv_cfg_if.sv
sv/spv_sample_mem.sv
sv/spv_mod_unit.sv
sv/spv_coef.sv
sv/stereo_sample_playback_voice.sv
tb/sv/tb_stereo_sample_playback_voice.sv
